// ----- sv/ddcb_pkg.sv -----
// Shared types, constants and helper functions for the differential drive command balancer.
// Used by the top level and by its port checker; depends on nothing else.
package ddcb_pkg;

	// Width of the encoder positions that are actually compared (low bits of each port).
	localparam int ENCODER_BITS = 32;
	localparam int GAP_W        = ENCODER_BITS + 1;
	localparam int THRESH_W     = 16;
	localparam int CMP_W        = (GAP_W > THRESH_W) ? GAP_W : THRESH_W;

	// Largest duty in hundredths.
	localparam logic [6:0] DUTY_MAX = 7'd100;

	// Register reset values.
	localparam logic [6:0]          RIGHT_START_RST = 7'd70;
	localparam logic [6:0]          LEFT_START_RST  = 7'd82;
	localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 16'd10;
	localparam logic [6:0]          TRIM_STEP_RST   = 7'd1;
	localparam logic [6:0]          DUTY_LIMIT_RST  = 7'd100;

	typedef logic [6:0]        duty_t;
	typedef logic signed [7:0] drive_t;

	// Drive commands.
	typedef enum logic [7:0] {
		CMD_STOP    = 8'd0,
		CMD_FORWARD = 8'd1,
		CMD_BACK    = 8'd2,
		CMD_LEFT    = 8'd3,
		CMD_RIGHT   = 8'd4,
		CMD_STOP_B  = 8'd5
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_RIGHT_START = 3'd0,
		REG_LEFT_START  = 3'd1,
		REG_THRESHOLD   = 3'd2,
		REG_TRIM_STEP   = 3'd3,
		REG_DUTY_LIMIT  = 3'd4
	} reg_idx_t;

	// Which side was trimmed in a period.
	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_RIGHT = 2'd2
	} side_t;

	// One result item.
	typedef struct packed {
		side_t  trimmed_side;
		logic   clear_encoders;
		drive_t left_drive;
		drive_t right_drive;
	} result_t;

	// Clamp an eight-bit unsigned value to the duty range.
	function automatic duty_t sat_duty(input logic [7:0] v);
		if (v > {1'b0, DUTY_MAX}) begin
			return DUTY_MAX;
		end
		return v[6:0];
	endfunction

	// Signed drive from a duty, positive or negated.
	function automatic drive_t drive_of(input duty_t d, input logic neg);
		logic [7:0] ext;
		ext = {1'b0, d};
		if (neg) begin
			return drive_t'(-ext);
		end
		return drive_t'(ext);
	endfunction

endpackage

// ----- sv/diff_drive_command_balancer_top.sv -----
// Balancer top level, built on ddcb_pkg. A request passes through the input register and
// then the result register. One request per cycle unless the result stalls; the duties
// change as a request enters the result register, so each one sees the duties left by
// the one before it. A stalled result holds its register; the input register still takes
// a request while it is empty. Reset (arst_n low, asynchronous) empties both stages and
// loads the register defaults, duties of 70 and 82 and held drives of zero.
module diff_drive_command_balancer_top
	import ddcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // command[7:0], right_encoder[39:8], left_encoder[71:40]
	input  logic        s_axis_tuser,  // active
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // right_drive[7:0], left_drive[15:8],
	                                   // clear_encoders[16], trimmed_side[18:17], zeros
);

	// Configuration registers
	duty_t               right_start_q;
	duty_t               left_start_q;
	logic [THRESH_W-1:0] threshold_q;
	duty_t               trim_step_q;
	duty_t               duty_limit_q;

	// Block state
	duty_t  right_pwm_q;
	duty_t  left_pwm_q;
	drive_t held_right_q;
	drive_t held_left_q;

	// Input stage
	logic                    valid_s1;
	logic [7:0]              cmd_s1;
	logic                    act_s1;
	logic [ENCODER_BITS-1:0] renc_s1;
	logic [ENCODER_BITS-1:0] lenc_s1;

	// Result stage
	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	result_t res;
	duty_t   right_pwm_d;
	duty_t   left_pwm_d;

	logic signed [GAP_W-1:0] diff;
	logic [GAP_W-1:0]        gap;
	logic                    below_limit;
	logic                    gap_big;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_q};

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_start_q <= RIGHT_START_RST;
			left_start_q  <= LEFT_START_RST;
			threshold_q   <= THRESHOLD_RST;
			trim_step_q   <= TRIM_STEP_RST;
			duty_limit_q  <= DUTY_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RIGHT_START: right_start_q <= cfg_data[6:0];
				REG_LEFT_START:  left_start_q  <= cfg_data[6:0];
				REG_THRESHOLD:   threshold_q   <= cfg_data;
				REG_TRIM_STEP:   trim_step_q   <= cfg_data[6:0];
				REG_DUTY_LIMIT:  duty_limit_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tdata[7:0];
			act_s1  <= s_axis_tuser;
			renc_s1 <= s_axis_tdata[8 +: ENCODER_BITS];
			lenc_s1 <= s_axis_tdata[40 +: ENCODER_BITS];
		end
	end

	// Encoder gap, computed one bit wider so that it never overflows.
	always_comb begin
		diff        = $signed({renc_s1[ENCODER_BITS-1], renc_s1})
		            - $signed({lenc_s1[ENCODER_BITS-1], lenc_s1});
		gap         = diff[GAP_W-1] ? GAP_W'(-diff) : GAP_W'(diff);
		below_limit = (right_pwm_q < duty_limit_q) && (left_pwm_q < duty_limit_q);
		gap_big     = CMP_W'(gap) > CMP_W'(threshold_q);
	end

	// Command mapping and forward balancing.
	always_comb begin
		res.right_drive    = held_right_q;
		res.left_drive     = held_left_q;
		res.clear_encoders = 1'b0;
		res.trimmed_side   = SIDE_NONE;
		right_pwm_d        = right_pwm_q;
		left_pwm_d         = left_pwm_q;
		if (!act_s1) begin
			res.right_drive = '0;
			res.left_drive  = '0;
			right_pwm_d     = sat_duty({1'b0, right_start_q});
			left_pwm_d      = sat_duty({1'b0, left_start_q});
		end else begin
			unique case (cmd_s1)
				CMD_STOP, CMD_STOP_B: begin
					res.right_drive = '0;
					res.left_drive  = '0;
				end
				CMD_FORWARD: begin
					res.right_drive = drive_of(right_pwm_q, 1'b0);
					res.left_drive  = drive_of(left_pwm_q, 1'b0);
					if (below_limit) begin
						res.clear_encoders = 1'b1;
						if (gap_big) begin
							if (!diff[GAP_W-1] && diff != '0) begin
								left_pwm_d       = sat_duty(8'(left_pwm_q) + 8'(trim_step_q));
								res.trimmed_side = SIDE_LEFT;
							end else begin
								right_pwm_d      = sat_duty(8'(right_pwm_q) + 8'(trim_step_q));
								res.trimmed_side = SIDE_RIGHT;
							end
						end
					end
				end
				CMD_BACK: begin
					res.right_drive = drive_of(right_pwm_q, 1'b1);
					res.left_drive  = drive_of(left_pwm_q, 1'b1);
				end
				// Turns use the duties crossed over.
				CMD_LEFT: begin
					res.right_drive = drive_of(left_pwm_q, 1'b0);
					res.left_drive  = drive_of(right_pwm_q, 1'b1);
				end
				CMD_RIGHT: begin
					res.right_drive = drive_of(left_pwm_q, 1'b1);
					res.left_drive  = drive_of(right_pwm_q, 1'b0);
				end
				default: ;
			endcase
		end
	end

	// Result register and state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			right_pwm_q  <= sat_duty({1'b0, RIGHT_START_RST});
			left_pwm_q   <= sat_duty({1'b0, LEFT_START_RST});
			held_right_q <= '0;
			held_left_q  <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				right_pwm_q  <= right_pwm_d;
				left_pwm_q   <= left_pwm_d;
				held_right_q <= res.right_drive;
				held_left_q  <= res.left_drive;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

endmodule

// ----- sv/ddcb_checker.sv -----
// Port-level checks for the differential drive command balancer, bound to its top level.
// Depends on ddcb_pkg for the result layout, side codes and the duty bound.
module ddcb_checker
	import ddcb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	result_t r;
	assign r = m_axis_tdata[$bits(result_t)-1:0];

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A trim only happens on a period that also clears the encoders.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.trimmed_side != SIDE_NONE |-> r.clear_encoders)
		else $error("trim without encoder clear");

	// Clearing happens only on forward drive, so both drives are non-negative.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.clear_encoders |-> !r.right_drive[7] && !r.left_drive[7])
		else $error("encoder clear with reverse drive");

	// Drives stay within the duty range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.right_drive <= $signed({1'b0, DUTY_MAX})
			&& r.right_drive >= -$signed({1'b0, DUTY_MAX})
			&& r.left_drive <= $signed({1'b0, DUTY_MAX})
			&& r.left_drive >= -$signed({1'b0, DUTY_MAX}))
		else $error("drive out of range");

endmodule

bind diff_drive_command_balancer_top ddcb_checker u_ddcb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_diff_drive_command_balancer_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the differential drive command balancer; a scoreboard
// class predicts every result from the requests it has seen.
// Depends on ddcb_pkg and on diff_drive_command_balancer_top.
module tb_diff_drive_command_balancer_top;
	import ddcb_pkg::*;

	// Command values that the block treats as "hold the last drives".
	localparam logic [7:0]  CMD_HOLD_LOW  = 8'd6;
	localparam logic [7:0]  CMD_HOLD_MAX  = 8'd255;
	// A register index past the end of the register list; writes to it are ignored.
	localparam logic [2:0]  REG_UNUSED    = 3'd7;
	localparam logic [31:0] ENC_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] ENC_MIN       = 32'h8000_0000;
	localparam int          IDLE_PERCENT  = 38;
	localparam int          PHASE_ITEMS   = 200;
	localparam int          PHASES        = 8;

	// Predicts each result from the duties, held drives and registers it keeps.
	class drive_scoreboard;
		duty_t               right_start, left_start, trim_step, duty_limit;
		logic [THRESH_W-1:0] threshold;
		duty_t               right_pwm, left_pwm;
		drive_t              held_right, held_left;
		result_t             expected_q[$];
		int                  errors;

		function new();
			right_start = RIGHT_START_RST;
			left_start  = LEFT_START_RST;
			threshold   = THRESHOLD_RST;
			trim_step   = TRIM_STEP_RST;
			duty_limit  = DUTY_LIMIT_RST;
			right_pwm   = clamp_duty(int'(right_start));
			left_pwm    = clamp_duty(int'(left_start));
			held_right  = '0;
			held_left   = '0;
			errors      = 0;
		endfunction

		function duty_t clamp_duty(int v);
			return (v > int'(DUTY_MAX)) ? DUTY_MAX : duty_t'(v);
		endfunction

		function void write_register(logic [2:0] idx, logic [15:0] value);
			case (idx)
				REG_RIGHT_START: right_start = value[6:0];
				REG_LEFT_START:  left_start  = value[6:0];
				REG_THRESHOLD:   threshold   = value[THRESH_W-1:0];
				REG_TRIM_STEP:   trim_step   = value[6:0];
				REG_DUTY_LIMIT:  duty_limit  = value[6:0];
				default: ;
			endcase
		endfunction

		// Work out the result of one accepted request and queue it.
		function void note_request(logic [7:0] cmd, logic act, logic [31:0] renc_raw,
			logic [31:0] lenc_raw);
			result_t want;
			longint  renc, lenc, gap;
			int      rd, ld;
			want = '0;
			renc = longint'($signed(renc_raw[ENCODER_BITS-1:0]));
			lenc = longint'($signed(lenc_raw[ENCODER_BITS-1:0]));
			rd   = int'(right_pwm);
			ld   = int'(left_pwm);
			if (!act) begin
				held_right = '0;
				held_left  = '0;
				right_pwm  = clamp_duty(int'(right_start));
				left_pwm   = clamp_duty(int'(left_start));
			end else begin
				case (cmd)
					CMD_STOP, CMD_STOP_B: begin
						held_right = '0;
						held_left  = '0;
					end
					CMD_FORWARD: begin
						held_right = drive_t'(rd);
						held_left  = drive_t'(ld);
						// Balancing only while both duties are under the limit.
						if (right_pwm < duty_limit && left_pwm < duty_limit) begin
							want.clear_encoders = 1'b1;
							gap = renc - lenc;
							if (gap < 0) begin
								gap = -gap;
							end
							if (gap > longint'(threshold)) begin
								if (renc > lenc) begin
									left_pwm = clamp_duty(ld + int'(trim_step));
									want.trimmed_side = SIDE_LEFT;
								end else begin
									right_pwm = clamp_duty(rd + int'(trim_step));
									want.trimmed_side = SIDE_RIGHT;
								end
							end
						end
					end
					CMD_BACK: begin
						held_right = drive_t'(-rd);
						held_left  = drive_t'(-ld);
					end
					// The turns use the duties crossed over.
					CMD_LEFT: begin
						held_right = drive_t'(ld);
						held_left  = drive_t'(-rd);
					end
					CMD_RIGHT: begin
						held_right = drive_t'(-ld);
						held_left  = drive_t'(rd);
					end
					default: ;
				endcase
			end
			want.right_drive = held_right;
			want.left_drive  = held_left;
			expected_q.insert(expected_q.size(), want);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [23:0] data);
			result_t got, want;
			got = result_t'(data[$bits(result_t)-1:0]);
			if (expected_q.size() == 0) begin
				$error("result %h arrived with no request outstanding", data);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.right_drive !== want.right_drive) begin
				$error("right_drive: expected %0d, actual %0d", want.right_drive,
					got.right_drive);
				errors++;
			end
			if (got.left_drive !== want.left_drive) begin
				$error("left_drive: expected %0d, actual %0d", want.left_drive,
					got.left_drive);
				errors++;
			end
			if (got.clear_encoders !== want.clear_encoders) begin
				$error("clear_encoders: expected %0b, actual %0b", want.clear_encoders,
					got.clear_encoders);
				errors++;
			end
			if (got.trimmed_side !== want.trimmed_side) begin
				$error("trimmed_side: expected %0d, actual %0d", want.trimmed_side,
					got.trimmed_side);
				errors++;
			end
			if (data[23:$bits(result_t)] !== '0) begin
				$error("padding: expected 0, actual %h", data[23:$bits(result_t)]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	// While set, neither side idles.
	logic steady = 1'b0;

	drive_scoreboard sb = new();

	diff_drive_command_balancer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: check every accepted result and stall at random.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
		end
		m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Offer one request, with random idle cycles ahead of it, and note it once accepted.
	task automatic send_request(input logic [7:0] cmd, input logic act,
		input logic [31:0] renc, input logic [31:0] lenc);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {lenc, renc, cmd};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(cmd, act, renc, lenc);
	endtask

	// Stop sending and wait until every outstanding request has its result.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, value);
	endtask

	task automatic apply_settings(input logic [15:0] rs, input logic [15:0] ls,
		input logic [15:0] thr, input logic [15:0] ts, input logic [15:0] lim,
		input logic stray);
		write_register(REG_RIGHT_START, rs);
		write_register(REG_LEFT_START, ls);
		write_register(REG_THRESHOLD, thr);
		write_register(REG_TRIM_STEP, ts);
		write_register(REG_DUTY_LIMIT, lim);
		if (stray) begin
			write_register(REG_UNUSED, 16'(($urandom())));
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] random_duty_word();
		if ($urandom_range(0, 4) == 0) begin
			return 16'($urandom());
		end
		return 16'($urandom_range(0, 100));
	endfunction

	function automatic logic [7:0] random_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return CMD_FORWARD;
		if (pick < 58) return CMD_BACK;
		if (pick < 66) return CMD_LEFT;
		if (pick < 74) return CMD_RIGHT;
		if (pick < 82) return CMD_STOP;
		if (pick < 86) return CMD_STOP_B;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] extreme_position();
		case ($urandom_range(0, 4))
			0: return ENC_MAX;
			1: return ENC_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Encoder pairs mostly straddle the threshold so that trims happen often.
	task automatic pick_encoders(output logic [31:0] renc, output logic [31:0] lenc);
		int     mode;
		longint gap;
		mode = $urandom_range(0, 99);
		if (mode < 60) begin
			gap = longint'(sb.threshold) + longint'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1)) begin
				gap = -gap;
			end
			lenc = $urandom();
			renc = lenc + 32'(gap);
		end else if (mode < 85) begin
			renc = $urandom();
			lenc = $urandom();
		end else begin
			renc = extreme_position();
			lenc = extreme_position();
		end
	endtask

	task automatic run_phase(input int count, input int hold_off_at);
		logic [7:0]  cmd;
		logic        act;
		logic [31:0] renc, lenc;
		for (int i = 0; i < count; i++) begin
			if (i == hold_off_at) begin
				wait_drained();
			end
			cmd = random_command();
			act = ($urandom_range(0, 99) >= 6);
			pick_encoders(renc, lenc);
			send_request(cmd, act, renc, lenc);
		end
		wait_drained();
	endtask

	// Main sequence: reset, a directed pass under the default registers,
	// then random phases under extreme, default and random settings.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Forward with no gap, with each side ahead, with the gap equal to the
		// threshold, and with the widest possible gaps.
		send_request(CMD_FORWARD, 1'b1, 32'd0, 32'd0);
		send_request(CMD_FORWARD, 1'b1, 32'd100, 32'd50);
		send_request(CMD_FORWARD, 1'b1, 32'd0, 32'd11);
		send_request(CMD_FORWARD, 1'b1, 32'd10, 32'd0);
		send_request(CMD_FORWARD, 1'b1, ENC_MAX, ENC_MIN);
		send_request(CMD_FORWARD, 1'b1, ENC_MIN, ENC_MAX);
		send_request(CMD_FORWARD, 1'b1, '1, '0);
		// Every other command, and the hold values either side of them.
		send_request(CMD_BACK, 1'b1, ENC_MAX, ENC_MAX);
		send_request(CMD_HOLD_LOW, 1'b1, '0, '1);
		send_request(CMD_LEFT, 1'b1, '0, '0);
		send_request(CMD_HOLD_MAX, 1'b1, '1, '1);
		send_request(CMD_RIGHT, 1'b1, '0, '0);
		send_request(CMD_STOP, 1'b1, '0, '0);
		send_request(CMD_HOLD_LOW, 1'b1, '0, '0);
		send_request(CMD_LEFT, 1'b1, '0, '0);
		send_request(CMD_STOP_B, 1'b1, '0, '0);
		send_request(CMD_RIGHT, 1'b1, '0, '0);
		// Inactive periods stop the motors and reload the start duties.
		send_request(CMD_FORWARD, 1'b0, 32'd500, 32'd0);
		send_request(CMD_HOLD_MAX, 1'b1, '0, '0);
		send_request(CMD_HOLD_MAX, 1'b0, '1, '0);
		send_request(CMD_FORWARD, 1'b1, 32'd0, 32'd500);
		send_request(CMD_BACK, 1'b1, '0, '0);
		wait_drained();

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				// Every register at its widest: start duties saturate at 100.
				1: apply_settings('1, '1, '1, '1, '1, 1'b0);
				// Everything zero: a limit of zero disables balancing.
				2: apply_settings('0, '0, '0, '0, '0, 1'b1);
				// Duties from zero and large steps up to saturation.
				3: apply_settings('0, '0, '0, 16'd100, 16'd1, 1'b0);
				4: apply_settings(16'(RIGHT_START_RST), 16'(LEFT_START_RST),
					16'(THRESHOLD_RST), 16'(TRIM_STEP_RST), 16'(DUTY_LIMIT_RST), 1'b1);
				default: apply_settings(random_duty_word(), random_duty_word(),
					($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40)),
					($urandom_range(0, 3) == 0) ? random_duty_word() : 16'($urandom_range(0, 6)),
					random_duty_word(), 1'b0);
			endcase
			// Open with an inactive period so the new start duties take effect.
			send_request(CMD_STOP, 1'b0, '0, '0);
			steady = (p == 4);
			run_phase(PHASE_ITEMS, (p == 5) ? PHASE_ITEMS / 2 : -1);
			steady = 1'b0;
		end

		wait_drained();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
